// File: sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths shared by the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int COORD_W    = 32;  // Q16.16 vertex coordinate
  localparam int EDGE_W     = 33;  // exact vertex difference
  localparam int UNIT_FRAC  = 30;  // fraction bits of a unit edge
  localparam int UNIT_W     = 32;  // signed unit edge component
  localparam int NMAG_W     = 31;  // normalized magnitude, top bit at bit 30
  localparam int SQ_W       = 62;  // square of a normalized magnitude
  localparam int SUM_W      = 64;  // sum of three squares
  localparam int ROOT_W     = 32;  // integer square root of the sum
  localparam int SQRT_STEPS = 32;  // one result bit per stage
  localparam int PROD_W     = 64;  // cross product term
  localparam int NORM_W     = 16;  // output component

endpackage

// File: sv/tfn_vertex_if.sv
// ----------------------------------------------------------------------------
// tfn_vertex_if
// Triangle input channel: three vertices with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tfn_vertex_if import tfn_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_a_x;
  logic signed [COORD_W-1:0] vertex_a_y;
  logic signed [COORD_W-1:0] vertex_a_z;
  logic signed [COORD_W-1:0] vertex_b_x;
  logic signed [COORD_W-1:0] vertex_b_y;
  logic signed [COORD_W-1:0] vertex_b_z;
  logic signed [COORD_W-1:0] vertex_c_x;
  logic signed [COORD_W-1:0] vertex_c_y;
  logic signed [COORD_W-1:0] vertex_c_z;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_a_z,
           vertex_b_x, vertex_b_y, vertex_b_z,
           vertex_c_x, vertex_c_y, vertex_c_z,
    input  ready
  );

  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_a_z,
           vertex_b_x, vertex_b_y, vertex_b_z,
           vertex_c_x, vertex_c_y, vertex_c_z,
    output ready
  );

endinterface

// File: sv/tfn_normal_if.sv
// ----------------------------------------------------------------------------
// tfn_normal_if
// Normal output channel: unit normal with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tfn_normal_if import tfn_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] normal_x;
  logic signed [NORM_W-1:0] normal_y;
  logic signed [NORM_W-1:0] normal_z;

  modport source (
    output valid, normal_x, normal_y, normal_z,
    input  ready
  );

  modport sink (
    input  valid, normal_x, normal_y, normal_z,
    output ready
  );

endinterface

// File: sv/tfn_unitize.sv
// ----------------------------------------------------------------------------
// tfn_unitize
// Pipelined scaling of a signed 3-vector to unit length: magnitude and sign,
// block normalization, sum of squares, one root bit per stage, one quotient
// bit per stage, then rounding clamp and sign. A zero vector gives zero.
// ----------------------------------------------------------------------------
module tfn_unitize import tfn_pkg::*; #(
  parameter int IN_W  = 33,
  parameter int FRAC  = 30,
  parameter int OUT_W = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ce,
  input  logic                    vin,
  input  logic signed [IN_W-1:0]  vec [3],
  output logic                    vout,
  output logic signed [OUT_W-1:0] unit [3]
);

  localparam int SH_W      = $clog2(IN_W);
  localparam int DIV_STEPS = FRAC + 1;
  localparam int Q_W       = FRAC + 1;
  localparam int NUM_W     = NMAG_W + FRAC + 1;
  localparam int SIDE_W    = 3 * NMAG_W + 4;
  localparam int NSTG      = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  // stage 1: magnitude and sign
  logic [IN_W-1:0] mag1 [3];
  logic [2:0]      neg1;
  // stage 2: largest magnitude
  logic [IN_W-1:0] mx;
  logic [IN_W-1:0] m2;
  logic [IN_W-1:0] mag2 [3];
  logic [2:0]      neg2;
  // stage 3: top set bit
  logic [SH_W-1:0] msb;
  logic [SH_W-1:0] msb3;
  logic            zero3;
  logic [IN_W-1:0] mag3 [3];
  logic [2:0]      neg3;
  // stage 4: normalized magnitudes
  logic [NMAG_W-1:0] nm [3];
  logic [SIDE_W-1:0] side4;
  // stage 5: squares
  logic [SQ_W-1:0]   sq5 [3];
  logic [SIDE_W-1:0] side5;
  // stage 6 and root stages
  logic [SUM_W-1:0]  sx [SQRT_STEPS+1];
  logic [SUM_W-1:0]  sr [SQRT_STEPS+1];
  logic [SIDE_W-1:0] sside [SQRT_STEPS+1];
  logic [SUM_W-1:0]  sx_next [SQRT_STEPS];
  logic [SUM_W-1:0]  sr_next [SQRT_STEPS];
  // divide stages
  logic [NUM_W-1:0]  drem [DIV_STEPS+1][3];
  logic [Q_W-1:0]    dq   [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] dlen [DIV_STEPS+1];
  logic [2:0]        dneg [DIV_STEPS+1];
  logic              dzero [DIV_STEPS+1];
  logic [NUM_W-1:0]  drem_next [DIV_STEPS][3];
  logic [Q_W-1:0]    dq_next   [DIV_STEPS][3];
  logic [ROOT_W-1:0] len;
  logic [Q_W-1:0]    qc [3];

  logic [NSTG-1:0] vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (ce) begin
      vp <= {vp[NSTG-2:0], vin};
    end
  end

  assign vout = vp[NSTG-1];

  always_comb begin
    mx = mag1[0];
    if (mag1[1] > mx) mx = mag1[1];
    if (mag1[2] > mx) mx = mag1[2];
  end

  always_comb begin
    msb = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (m2[b]) msb = SH_W'(b);
    end
  end

  // line the largest magnitude up with bit NMAG_W-1; right shifts truncate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (msb3 > SH_W'(NMAG_W - 1)) begin
        nm[c] = NMAG_W'(mag3[c] >> (msb3 - SH_W'(NMAG_W - 1)));
      end else begin
        nm[c] = NMAG_W'(mag3[c]) << (SH_W'(NMAG_W - 1) - msb3);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (sx[k] >= sr[k] + (SUM_W'(1) << (SUM_W - 2 - 2 * k))) begin
        sx_next[k] = sx[k] - (sr[k] + (SUM_W'(1) << (SUM_W - 2 - 2 * k)));
        sr_next[k] = (sr[k] >> 1) + (SUM_W'(1) << (SUM_W - 2 - 2 * k));
      end else begin
        sx_next[k] = sx[k];
        sr_next[k] = sr[k] >> 1;
      end
    end
  end

  assign len = ROOT_W'(sr[SQRT_STEPS]);

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int c = 0; c < 3; c++) begin
        if (drem[j][c] >= (NUM_W'(dlen[j]) << (FRAC - j))) begin
          drem_next[j][c] = drem[j][c] - (NUM_W'(dlen[j]) << (FRAC - j));
          dq_next[j][c]   = dq[j][c] | (Q_W'(1) << (FRAC - j));
        end else begin
          drem_next[j][c] = drem[j][c];
          dq_next[j][c]   = dq[j][c];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dq[DIV_STEPS][c] > (Q_W'(1) << FRAC)) begin
        qc[c] = Q_W'(1) << FRAC;
      end else begin
        qc[c] = dq[DIV_STEPS][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) begin
        neg1[c] <= vec[c][IN_W-1];
        mag1[c] <= vec[c][IN_W-1] ? IN_W'(-vec[c]) : IN_W'(vec[c]);
      end
      m2   <= mx;
      mag2 <= mag1;
      neg2 <= neg1;

      msb3  <= msb;
      zero3 <= (m2 == '0);
      mag3  <= mag2;
      neg3  <= neg2;

      side4 <= {zero3, neg3, nm[2], nm[1], nm[0]};

      for (int c = 0; c < 3; c++) begin
        sq5[c] <= SQ_W'(side4[c*NMAG_W +: NMAG_W]) * SQ_W'(side4[c*NMAG_W +: NMAG_W]);
      end
      side5 <= side4;

      sx[0]    <= SUM_W'(sq5[0]) + SUM_W'(sq5[1]) + SUM_W'(sq5[2]);
      sr[0]    <= '0;
      sside[0] <= side5;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sx[k+1]    <= sx_next[k];
        sr[k+1]    <= sr_next[k];
        sside[k+1] <= sside[k];
      end

      // dividend carries half the root so the quotient rounds half away
      for (int c = 0; c < 3; c++) begin
        drem[0][c] <= (NUM_W'(sside[SQRT_STEPS][c*NMAG_W +: NMAG_W]) << FRAC)
                      + NUM_W'(len >> 1);
        dq[0][c]   <= '0;
      end
      dlen[0]  <= len;
      dneg[0]  <= sside[SQRT_STEPS][SIDE_W-2 -: 3];
      dzero[0] <= sside[SQRT_STEPS][SIDE_W-1];
      for (int j = 0; j < DIV_STEPS; j++) begin
        drem[j+1]  <= drem_next[j];
        dq[j+1]    <= dq_next[j];
        dlen[j+1]  <= dlen[j];
        dneg[j+1]  <= dneg[j];
        dzero[j+1] <= dzero[j];
      end

      for (int c = 0; c < 3; c++) begin
        if (dzero[DIV_STEPS]) begin
          unit[c] <= '0;
        end else if (dneg[DIV_STEPS][c]) begin
          unit[c] <= -OUT_W'(qc[c]);
        end else begin
          unit[c] <= OUT_W'(qc[c]);
        end
      end
    end
  end

endmodule

// File: sv/triangle_face_normal.sv
// Throughput: one triangle per cycle; every stage holds on a full skid stage.
// Output register plus one skid entry decouple ready from the pipeline.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle: unit edges, cross product, unit normal.
// ----------------------------------------------------------------------------
module triangle_face_normal import tfn_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input logic         clk,
  input logic         rst,
  tfn_vertex_if.sink  vtx,
  tfn_normal_if.source nrm
);

  localparam int NRM_UW = NORMAL_FRAC_BITS + 2;
  localparam int LIM_HI = (NORMAL_FRAC_BITS >= 15) ? 32767 : (1 << NORMAL_FRAC_BITS);
  localparam int LIM_LO = (NORMAL_FRAC_BITS >= 15) ? -32768 : -(1 << NORMAL_FRAC_BITS);

  logic ce;

  logic                     vld1;
  logic signed [EDGE_W-1:0] ue [3];
  logic signed [EDGE_W-1:0] ve [3];

  logic                     uvld;
  logic                     vvld;
  logic signed [UNIT_W-1:0] un [3];
  logic signed [UNIT_W-1:0] vn [3];

  logic                     vld2;
  logic signed [PROD_W-1:0] pr [6];
  logic                     vld3;
  logic signed [PROD_W-1:0] cr [3];

  logic                     nvld;
  logic signed [NRM_UW-1:0] nn [3];
  logic signed [33:0]       ext [3];

  logic                     p_valid;
  logic signed [NORM_W-1:0] p_n [3];
  logic                     o_valid;
  logic signed [NORM_W-1:0] o_n [3];
  logic                     s_valid;
  logic signed [NORM_W-1:0] s_n [3];

  // hold the whole pipeline only while the skid entry is occupied
  assign ce        = !s_valid;
  assign vtx.ready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      p_valid <= 1'b0;
    end else if (ce) begin
      vld1 <= vtx.valid;
      vld2 <= uvld;
      vld3 <= vld2;
      p_valid <= nvld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ue[0] <= EDGE_W'(vtx.vertex_b_x) - EDGE_W'(vtx.vertex_a_x);
      ue[1] <= EDGE_W'(vtx.vertex_b_y) - EDGE_W'(vtx.vertex_a_y);
      ue[2] <= EDGE_W'(vtx.vertex_b_z) - EDGE_W'(vtx.vertex_a_z);
      ve[0] <= EDGE_W'(vtx.vertex_c_x) - EDGE_W'(vtx.vertex_a_x);
      ve[1] <= EDGE_W'(vtx.vertex_c_y) - EDGE_W'(vtx.vertex_a_y);
      ve[2] <= EDGE_W'(vtx.vertex_c_z) - EDGE_W'(vtx.vertex_a_z);
    end
  end

  tfn_unitize #(.IN_W(EDGE_W), .FRAC(UNIT_FRAC), .OUT_W(UNIT_W)) u_unit_u (
    .clk(clk), .rst(rst), .ce(ce), .vin(vld1), .vec(ue), .vout(uvld), .unit(un)
  );

  tfn_unitize #(.IN_W(EDGE_W), .FRAC(UNIT_FRAC), .OUT_W(UNIT_W)) u_unit_v (
    .clk(clk), .rst(rst), .ce(ce), .vin(vld1), .vec(ve), .vout(vvld), .unit(vn)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      pr[0] <= PROD_W'(un[1]) * PROD_W'(vn[2]);
      pr[1] <= PROD_W'(un[2]) * PROD_W'(vn[1]);
      pr[2] <= PROD_W'(un[2]) * PROD_W'(vn[0]);
      pr[3] <= PROD_W'(un[0]) * PROD_W'(vn[2]);
      pr[4] <= PROD_W'(un[0]) * PROD_W'(vn[1]);
      pr[5] <= PROD_W'(un[1]) * PROD_W'(vn[0]);
      cr[0] <= pr[0] - pr[1];
      cr[1] <= pr[2] - pr[3];
      cr[2] <= pr[4] - pr[5];
    end
  end

  tfn_unitize #(.IN_W(PROD_W), .FRAC(NORMAL_FRAC_BITS), .OUT_W(NRM_UW)) u_unit_n (
    .clk(clk), .rst(rst), .ce(ce), .vin(vld3), .vec(cr), .vout(nvld), .unit(nn)
  );

  // saturate to the output field
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ext[c] = 34'(nn[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 3; c++) begin
        if (ext[c] > 34'sd32767) begin
          p_n[c] <= 16'sh7fff;
        end else if (ext[c] < -34'sd32768) begin
          p_n[c] <= 16'sh8000;
        end else begin
          p_n[c] <= NORM_W'(ext[c]);
        end
      end
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (s_valid) begin
      if (nrm.ready) begin
        s_valid <= 1'b0;
      end
    end else if (p_valid) begin
      if (!o_valid || nrm.ready) begin
        o_valid <= 1'b1;
      end else begin
        s_valid <= 1'b1;
      end
    end else if (nrm.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid) begin
      if (nrm.ready) begin
        o_n <= s_n;
      end
    end else if (p_valid) begin
      if (!o_valid || nrm.ready) begin
        o_n <= p_n;
      end else begin
        s_n <= p_n;
      end
    end
  end

  assign nrm.valid    = o_valid;
  assign nrm.normal_x = o_n[0];
  assign nrm.normal_y = o_n[1];
  assign nrm.normal_z = o_n[2];

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid entry occupied with empty output register");

  a_edges_aligned: assert property (@(posedge clk) disable iff (rst)
    uvld == vvld)
    else $error("edge pipelines out of step");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    p_valid && !ce |=> p_valid)
    else $error("pipeline word lost during stall");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    s_valid && !nrm.ready |=> s_valid && $stable(s_n[0]) && $stable(s_n[2]))
    else $error("skid word dropped while output stalled");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_n[0] <= LIM_HI && o_n[0] >= LIM_LO && o_n[1] <= LIM_HI
                && o_n[1] >= LIM_LO && o_n[2] <= LIM_HI && o_n[2] >= LIM_LO)
    else $error("normal component out of unit range");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams triangles through triangle_face_normal and checks each unit normal
// word against an in-bench integer model, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import tfn_pkg::*;

  localparam int NFRAC      = 14;
  localparam int LATENCY    = 117 + NFRAC;
  localparam int N_RANDOM   = 900;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } triangle_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx, ny, nz;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfn_vertex_if vtx ();
  tfn_normal_if nrm ();

  triangle_face_normal #(.NORMAL_FRAC_BITS(NFRAC)) dut (
    .clk(clk), .rst(rst), .vtx(vtx.sink), .nrm(nrm.source)
  );

  always #1 clk = ~clk;

  triangle_t pending_tris[$];
  normal_t   expected_normals[$];
  int        mismatches = 0;
  int        normals_seen = 0;
  int        degenerate_seen = 0;
  int        idle_cycles = 0;
  bit        feed_done = 1'b0;

  // --------------------------------------------------------------------------
  // integer model of the unit-scaling datapath
  // --------------------------------------------------------------------------
  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > x) bits >>= 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  typedef logic signed [127:0] vec3_t [3];

  function automatic vec3_t scale_to_unit(vec3_t v, int frac);
    vec3_t       r;
    logic [127:0] mag[3];
    logic [127:0] top, sum, len, q, lim;
    bit          neg[3];
    int          msb;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) r[i] = 0;
      return r;
    end
    msb = 0;
    while ((top >> msb) > 1) msb++;
    for (int i = 0; i < 3; i++) begin
      if (msb > 30) mag[i] = mag[i] >> (msb - 30);
      else          mag[i] = mag[i] << (30 - msb);
      sum += mag[i] * mag[i];
    end
    len = int_sqrt(sum[63:0]);
    lim = 128'd1 << frac;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << frac) + (len >> 1)) / len;
      if (q > lim) q = lim;
      r[i] = neg[i] ? -$signed(q) : $signed(q);
    end
    return r;
  endfunction

  function automatic normal_t face_normal(triangle_t t);
    vec3_t   u, v, cr, n;
    normal_t res;
    logic signed [NORM_W-1:0] comp[3];
    u[0] = 128'(t.bx) - 128'(t.ax);
    u[1] = 128'(t.by) - 128'(t.ay);
    u[2] = 128'(t.bz) - 128'(t.az);
    v[0] = 128'(t.cx) - 128'(t.ax);
    v[1] = 128'(t.cy) - 128'(t.ay);
    v[2] = 128'(t.cz) - 128'(t.az);
    u = scale_to_unit(u, UNIT_FRAC);
    v = scale_to_unit(v, UNIT_FRAC);
    cr[0] = u[1] * v[2] - u[2] * v[1];
    cr[1] = u[2] * v[0] - u[0] * v[2];
    cr[2] = u[0] * v[1] - u[1] * v[0];
    n = scale_to_unit(cr, NFRAC);
    for (int i = 0; i < 3; i++) begin
      if (n[i] > 32767)       comp[i] = 16'sd32767;
      else if (n[i] < -32768) comp[i] = -16'sd32768;
      else                    comp[i] = n[i][15:0];
    end
    res.nx = comp[0];
    res.ny = comp[1];
    res.nz = comp[2];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
                                             : 32'sh8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic triangle_t make_tri(logic signed [31:0] ax, ay, az, bx, by, bz,
                                         cx, cy, cz);
    triangle_t t;
    t.ax = ax; t.ay = ay; t.az = az;
    t.bx = bx; t.by = by; t.bz = bz;
    t.cx = cx; t.cy = cy; t.cz = cz;
    return t;
  endfunction

  localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINC = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  initial begin
    triangle_t t;
    int        mode;
    // directed: axis-aligned, degenerate, extremes, nearly collinear
    pending_tris.push_back(make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, ONE, 0, 0, 0, ONE));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, ONE, ONE, 0, 0));
    pending_tris.push_back(make_tri(5, 6, 7, 5, 6, 7, 9, 9, 9));
    pending_tris.push_back(make_tri(5, 6, 7, 9, 9, 9, 5, 6, 7));
    pending_tris.push_back(make_tri(1, 1, 1, 1, 1, 1, 1, 1, 1));
    pending_tris.push_back(make_tri(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE));
    pending_tris.push_back(make_tri(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC));
    pending_tris.push_back(make_tri(MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MAXC, MINC));
    pending_tris.push_back(make_tri(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, MAXC));
    pending_tris.push_back(make_tri(MAXC, MINC, 0, MINC, MAXC, 0, 0, 0, MAXC));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_tris.push_back(make_tri(0, 0, 0, MAXC, 1, 0, MAXC, 0, 1));
    pending_tris.push_back(make_tri(0, 0, 0, MAXC, MAXC, 0, MAXC - 1, MAXC, 0));
    pending_tris.push_back(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, 0));
    pending_tris.push_back(make_tri(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                                    32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
                                    32'sh1234_5678, 32'shedcb_a987, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 3, 4, 0, 0, 0, -5));
    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(0, 3);
      t = make_tri(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                   rand_coord(mode), rand_coord(mode), rand_coord(mode),
                   rand_coord(mode), rand_coord(mode), rand_coord(mode));
      // sometimes collapse a vertex or align the edges
      case ($urandom_range(0, 15))
        0: begin t.bx = t.ax; t.by = t.ay; t.bz = t.az; end
        1: begin t.cx = t.bx; t.cy = t.by; t.cz = t.bz; end
        2: begin t.cx = t.ax; t.cy = t.ay; t.cz = t.az; end
        3: begin
          t.ax = rand_coord(1); t.ay = rand_coord(1); t.az = rand_coord(1);
          t.bx = t.ax + 3; t.by = t.ay + 5; t.bz = t.az - 7;
          t.cx = t.ax + 6; t.cy = t.ay + 10; t.cz = t.az - 14 + $urandom_range(0, 1);
        end
        default: ;
      endcase
      pending_tris.push_back(t);
    end
  end

  // --------------------------------------------------------------------------
  // driver: bursts and gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic put_word(triangle_t t);
    vtx.vertex_a_x <= t.ax; vtx.vertex_a_y <= t.ay; vtx.vertex_a_z <= t.az;
    vtx.vertex_b_x <= t.bx; vtx.vertex_b_y <= t.by; vtx.vertex_b_z <= t.bz;
    vtx.vertex_c_x <= t.cx; vtx.vertex_c_y <= t.cy; vtx.vertex_c_z <= t.cz;
  endtask

  always @(posedge clk) begin
    triangle_t t;
    if (rst) begin
      vtx.valid <= 1'b0;
      put_word('0);
    end else begin
      // drop the word the block just took and predict its normal
      if (vtx.valid && vtx.ready) begin
        t = pending_tris.pop_front();
        expected_normals.push_back(face_normal(t));
      end
      if ((vtx.valid && !vtx.ready) ) begin
        // hold the offered word
      end else if (pending_tris.size() == 0) begin
        vtx.valid <= 1'b0;
        feed_done <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        vtx.valid <= 1'b0;
      end else begin
        put_word(pending_tris[0]);
        vtx.valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver stall pattern, with one long hold-off
  // --------------------------------------------------------------------------
  int cycle_count = 0;
  int hold_off    = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 400) begin
      hold_off  <= 600;
      nrm.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      nrm.ready <= 1'b0;
    end else if (cycle_count[10]) begin
      nrm.ready <= 1'b1;
    end else begin
      nrm.ready <= ($urandom_range(0, 3) != 0) && !(cycle_count[5:3] == 3'd5);
    end
  end

  // --------------------------------------------------------------------------
  // monitor
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("MISMATCH %s: got %0d expected %0d (normal %0d)", what, got, want,
             normals_seen);
  endtask

  always @(posedge clk) begin
    normal_t want;
    if (!rst && nrm.valid && nrm.ready) begin
      if (expected_normals.size() == 0) begin
        report_mismatch("unexpected word", nrm.normal_x, 0);
      end else begin
        want = expected_normals.pop_front();
        if (nrm.normal_x !== want.nx) report_mismatch("normal_x", nrm.normal_x, want.nx);
        if (nrm.normal_y !== want.ny) report_mismatch("normal_y", nrm.normal_y, want.ny);
        if (nrm.normal_z !== want.nz) report_mismatch("normal_z", nrm.normal_z, want.nz);
        if (want == '0) degenerate_seen++;
      end
      normals_seen++;
    end
  end

  // watchdog: advance only while nothing moves
  always @(posedge clk) begin
    if ((vtx.valid && vtx.ready) || (nrm.valid && nrm.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("triangle_face_normal verification failed");
      $finish;
    end
  end

  initial begin
    wait (feed_done);
    wait (expected_normals.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("checked %0d normal words, %0d of them zero (degenerate)", normals_seen,
             degenerate_seen);
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("triangle_face_normal verification clean");
    end else begin
      $display("triangle_face_normal verification failed");
    end
    $finish;
  end

endmodule
